// ===== rtl/core/assert_macros.svh =====
// assertion macros for the packetizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define RTPFUA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rtpfua assertion failed");

// condition must never be seen outside reset
`define RTPFUA_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("rtpfua forbidden condition seen");

`endif

// ===== rtl/core/rtpfua_pkg.sv =====
// types, constants and helpers for the rtp fu-a packetizer
package rtpfua_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 4194304;

   localparam logic [10:0] MAX_PAYLOAD_LOW  = 11'd16;
   localparam logic [10:0] MAX_PAYLOAD_HIGH = 11'd1460;

   localparam logic [10:0] MAX_PAYLOAD_RESET  = 11'd1400;
   localparam logic [6:0]  PAYLOAD_TYPE_RESET = 7'd96;
   localparam logic [31:0] SSRC_RESET         = 32'd10;

   localparam logic [1:0] CSR_MAX_PAYLOAD  = 2'd0;
   localparam logic [1:0] CSR_PAYLOAD_TYPE = 2'd1;
   localparam logic [1:0] CSR_SSRC         = 2'd2;

   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [7:0] FU_NRI_MASK      = 8'hE0;
   localparam logic [7:0] FU_A_TYPE        = 8'd28;
   localparam logic [7:0] FU_TYPE_MASK     = 8'h1F;
   localparam logic [7:0] FU_START_BIT     = 8'h80;
   localparam logic [7:0] FU_END_BIT       = 8'h40;
   localparam logic [7:0] FU_KEEP_MASK     = 8'hBF;
   localparam logic [7:0] FU_CLEAR_MASK    = 8'h3F;

   // byte slots of one run
   localparam logic [3:0] IDX_VERSION  = 4'd0;
   localparam logic [3:0] IDX_PT       = 4'd1;
   localparam logic [3:0] IDX_SEQ_HI   = 4'd2;
   localparam logic [3:0] IDX_SEQ_LO   = 4'd3;
   localparam logic [3:0] IDX_TS_3     = 4'd4;
   localparam logic [3:0] IDX_TS_2     = 4'd5;
   localparam logic [3:0] IDX_TS_1     = 4'd6;
   localparam logic [3:0] IDX_TS_0     = 4'd7;
   localparam logic [3:0] IDX_SSRC_3   = 4'd8;
   localparam logic [3:0] IDX_SSRC_2   = 4'd9;
   localparam logic [3:0] IDX_SSRC_1   = 4'd10;
   localparam logic [3:0] IDX_SSRC_0   = 4'd11;
   localparam logic [3:0] IDX_FU_IND   = 4'd12;
   localparam logic [3:0] IDX_FU_HDR   = 4'd13;
   localparam logic [3:0] IDX_DATA     = 4'd14;

   typedef struct packed {
      logic [7:0]  data;
      logic        eop;
      logic        hdr;
      logic        fu;
      logic        marker;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [7:0]  fu_ind;
      logic [7:0]  fu_hdr;
   } desc_type;

   function automatic logic [10:0] sat_payload(input logic [10:0] value);
      logic [10:0] result;
      result = value;
      if (value < MAX_PAYLOAD_LOW) begin
         result = MAX_PAYLOAD_LOW;
      end else if (value > MAX_PAYLOAD_HIGH) begin
         result = MAX_PAYLOAD_HIGH;
      end
      return result;
   endfunction

endpackage

// ===== rtl/core/rtp_h264_fua_packetizer.sv =====
// top level of the rtp h.264 fu-a packetizer with its configuration registers
//
// req channel: one nal unit byte per item, with the frame size and rtp
// timestamp alongside; size and timestamp are taken on the first byte of a frame.
// rsp channel: one rtp packet stream byte per item, end_of_packet on the last
// byte of a packet and end_of_run on the last byte caused by an input item.
// csr port: write enable, index and data; 0 max payload, 1 payload type, 2 ssrc.
// a byte that opens a packet gives 13 result items, 15 when fragmented, and a
// byte inside a packet gives one; the first byte of a fragmented frame gives none.
// results leave through an output register one item per cycle while rsp_stall is
// low, so an input item holds the block while the serialiser walks the run
// descriptor. an accepted item is registered in the run descriptor register, its
// first result then in the output register. a new item is accepted in the cycle
// the last byte of the previous run enters the output register, so bytes inside a
// packet flow at one per cycle while not stalled. when the receiver stalls, the
// output register holds and req_stall rises once the pending run cannot advance.
// reset is synchronous and clears the control state; the sequence number restarts
// at one and registers return to their defaults.
module rtp_h264_fua_packetizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_nal_byte,
   input  logic [22:0] req_frame_size,
   input  logic [31:0] req_frame_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_packet,
   output logic        rsp_end_of_run,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import rtpfua_pkg::*;

   logic [10:0] max_payload_ff;
   logic [6:0]  payload_type_ff;
   logic [31:0] ssrc_ff;

   logic        accept;
   logic        push;
   logic        free;
   desc_type    desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff  <= MAX_PAYLOAD_RESET;
         payload_type_ff <= PAYLOAD_TYPE_RESET;
         ssrc_ff         <= SSRC_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAX_PAYLOAD:  max_payload_ff  <= csr_data[10:0];
            CSR_PAYLOAD_TYPE: payload_type_ff <= csr_data[6:0];
            CSR_SSRC:         ssrc_ff         <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = !free;
   assign accept    = req_valid && free;

   rtpfua_ctl u_ctl (
      .clock         (clock),
      .reset         (reset),
      .accept_i      (accept),
      .nal_byte_i    (req_nal_byte),
      .frame_size_i  (req_frame_size),
      .frame_time_i  (req_frame_time),
      .max_payload_i (max_payload_ff),
      .push_o        (push),
      .desc_o        (desc)
   );

   rtpfua_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .push_i            (push),
      .desc_i            (desc),
      .payload_type_i    (payload_type_ff),
      .ssrc_i            (ssrc_ff),
      .free_o            (free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_packet (rsp_end_of_packet),
      .rsp_end_of_run    (rsp_end_of_run)
   );

endmodule

// ===== rtl/core/rtpfua_ctl.sv =====
// frame and packet state tracking, builds one run descriptor per item but an absorbed first byte
module rtpfua_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept_i,
   input  logic [7:0]            nal_byte_i,
   input  logic [22:0]           frame_size_i,
   input  logic [31:0]           frame_time_i,
   input  logic [10:0]           max_payload_i,
   output logic                  push_o,
   output rtpfua_pkg::desc_type  desc_o
);
   import rtpfua_pkg::*;

   logic [15:0] seq_ff, seq_in;
   logic        active_ff, active_in;
   logic [22:0] rem_ff, rem_in;
   logic [10:0] fill_ff, fill_in;
   logic        frag_ff, frag_in;
   logic [7:0]  fu_ind_ff, fu_ind_in;
   logic [7:0]  fu_hdr_ff, fu_hdr_in;
   logic [31:0] ts_ff, ts_in;

   logic [10:0] mp;
   logic [10:0] mp_frag;
   logic        first;
   logic [22:0] size;
   logic        frag_w;
   logic [22:0] rem_w;
   logic [10:0] fill_w;
   logic [31:0] ts_w;
   logic        absorb;
   logic        hdr;
   logic        last;
   logic [7:0]  fu_hdr_w;
   logic [10:0] fill_n;
   logic [22:0] rem_n;
   logic        eop;

   always_comb begin
      mp      = sat_payload(max_payload_i);
      mp_frag = mp - 11'd2;
      first   = !active_ff;

      size = frame_size_i;
      if (frame_size_i == 23'd0) begin
         size = 23'd1;
      end else if ({9'd0, frame_size_i} > 32'(MAX_FRAME_BYTES)) begin
         size = 23'(MAX_FRAME_BYTES);
      end

      frag_w = first ? (size > {12'd0, mp}) : frag_ff;
      rem_w  = first ? size : rem_ff;
      fill_w = first ? 11'd0 : fill_ff;
      ts_w   = first ? frame_time_i : ts_ff;
      absorb = first && frag_w;

      hdr      = (fill_w == 11'd0);
      last     = !frag_w || (rem_w <= {12'd0, mp_frag});
      fu_hdr_w = (fu_hdr_ff & FU_KEEP_MASK) | (last ? FU_END_BIT : 8'd0);

      fill_n = fill_w + 11'd1;
      rem_n  = (rem_w != 23'd0) ? rem_w - 23'd1 : 23'd0;
      eop    = (rem_n == 23'd0) || (frag_w && (fill_n >= mp_frag));

      seq_in    = seq_ff;
      active_in = active_ff;
      rem_in    = rem_ff;
      fill_in   = fill_ff;
      frag_in   = frag_ff;
      fu_ind_in = fu_ind_ff;
      fu_hdr_in = fu_hdr_ff;
      ts_in     = ts_ff;

      if (accept_i) begin
         if (absorb) begin
            // first byte of a fragmented frame sets up the fu bytes and frame state, no descriptor
            fu_ind_in = (nal_byte_i & FU_NRI_MASK) | FU_A_TYPE;
            fu_hdr_in = FU_START_BIT | (nal_byte_i & FU_TYPE_MASK);
            active_in = 1'b1;
            rem_in    = size - 23'd1;
            frag_in   = 1'b1;
            fill_in   = 11'd0;
            ts_in     = frame_time_i;
         end else begin
            ts_in = ts_w;
            if (hdr) begin
               seq_in = seq_ff + 16'd1;
            end
            if (hdr && frag_w) begin
               fu_hdr_in = fu_hdr_w & FU_CLEAR_MASK;
            end
            fill_in   = eop ? 11'd0 : fill_n;
            rem_in    = rem_n;
            active_in = (rem_n != 23'd0);
            frag_in   = (rem_n != 23'd0) && frag_w;
         end
      end

      push_o        = accept_i && !absorb;
      desc_o.data   = nal_byte_i;
      desc_o.eop    = eop;
      desc_o.hdr    = hdr;
      desc_o.fu     = frag_w;
      desc_o.marker = last;
      desc_o.seq    = seq_ff;
      desc_o.ts     = ts_w;
      desc_o.fu_ind = fu_ind_ff;
      desc_o.fu_hdr = fu_hdr_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= 16'd1;
         active_ff <= 1'b0;
         rem_ff    <= 23'd0;
         fill_ff   <= 11'd0;
         frag_ff   <= 1'b0;
         fu_ind_ff <= 8'd0;
         fu_hdr_ff <= 8'd0;
         ts_ff     <= 32'd0;
      end else begin
         seq_ff    <= seq_in;
         active_ff <= active_in;
         rem_ff    <= rem_in;
         fill_ff   <= fill_in;
         frag_ff   <= frag_in;
         fu_ind_ff <= fu_ind_in;
         fu_hdr_ff <= fu_hdr_in;
         ts_ff     <= ts_in;
      end
   end

endmodule

// ===== rtl/core/rtpfua_emit.sv =====
// run descriptor register and byte serialiser with registered result
`include "assert_macros.svh"

module rtpfua_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_i,
   input  rtpfua_pkg::desc_type  desc_i,
   input  logic [6:0]            payload_type_i,
   input  logic [31:0]           ssrc_i,
   output logic                  free_o,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_end_of_packet,
   output logic                  rsp_end_of_run
);
   import rtpfua_pkg::*;

   desc_type    desc_ff, desc_in;
   logic        desc_valid_ff, desc_valid_in;
   logic [3:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        eop_ff, eop_in;
   logic        run_ff, run_in;

   logic        load;
   logic        done;
   logic [3:0]  idx_next;
   logic [7:0]  sel_byte;

   always_comb begin
      unique case (idx_ff)
         IDX_VERSION: sel_byte = RTP_VERSION_BYTE;
         IDX_PT:      sel_byte = {desc_ff.marker, payload_type_i};
         IDX_SEQ_HI:  sel_byte = desc_ff.seq[15:8];
         IDX_SEQ_LO:  sel_byte = desc_ff.seq[7:0];
         IDX_TS_3:    sel_byte = desc_ff.ts[31:24];
         IDX_TS_2:    sel_byte = desc_ff.ts[23:16];
         IDX_TS_1:    sel_byte = desc_ff.ts[15:8];
         IDX_TS_0:    sel_byte = desc_ff.ts[7:0];
         IDX_SSRC_3:  sel_byte = ssrc_i[31:24];
         IDX_SSRC_2:  sel_byte = ssrc_i[23:16];
         IDX_SSRC_1:  sel_byte = ssrc_i[15:8];
         IDX_SSRC_0:  sel_byte = ssrc_i[7:0];
         IDX_FU_IND:  sel_byte = desc_ff.fu_ind;
         IDX_FU_HDR:  sel_byte = desc_ff.fu_hdr;
         default:     sel_byte = desc_ff.data;
      endcase

      if (idx_ff == IDX_SSRC_0) begin
         idx_next = desc_ff.fu ? IDX_FU_IND : IDX_DATA;
      end else begin
         idx_next = idx_ff + 4'd1;
      end

      load   = desc_valid_ff && (!rsp_valid_ff || !rsp_stall);
      done   = load && (idx_ff == IDX_DATA);
      free_o = !desc_valid_ff || done;

      desc_in       = push_i ? desc_i : desc_ff;
      desc_valid_in = push_i || (desc_valid_ff && !done);
      if (push_i) begin
         idx_in = desc_i.hdr ? IDX_VERSION : IDX_DATA;
      end else if (load) begin
         idx_in = idx_next;
      end else begin
         idx_in = idx_ff;
      end

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      byte_in      = load ? sel_byte : byte_ff;
      eop_in       = load ? (done && desc_ff.eop) : eop_ff;
      run_in       = load ? done : run_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
         idx_ff        <= IDX_VERSION;
         rsp_valid_ff  <= 1'b0;
      end else begin
         desc_valid_ff <= desc_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      desc_ff <= desc_in;
      byte_ff <= byte_in;
      eop_ff  <= eop_in;
      run_ff  <= run_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_end_of_packet = eop_ff;
   assign rsp_end_of_run    = run_ff;

   `RTPFUA_ASSERT(a_eop_ends_run, clock, reset, (rsp_valid_ff && eop_ff) |-> run_ff)
   `RTPFUA_ASSERT(a_push_when_free, clock, reset, push_i |-> free_o)
   `RTPFUA_NEVER(a_idx_range, clock, reset, desc_valid_ff && (idx_ff > IDX_DATA))

endmodule
